// ===== rtl/calendar_datetime_add_seconds_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the date/time advance block
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATETIME_ADD_SECONDS_MACROS_SVH
`define CALENDAR_DATETIME_ADD_SECONDS_MACROS_SVH

// Same-cycle implication.
`define CDAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdas: same-cycle check failed");

// Next-cycle implication.
`define CDAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdas: next-cycle check failed");

`endif

// ===== rtl/cdas_pkg.sv =====
// ----------------------------------------------------------------------------
// cdas_pkg
// Constants, widths and helpers for the date/time advance block.
// ----------------------------------------------------------------------------
package cdas_pkg;

  localparam int unsigned NUM_STAGES = 7;

  localparam int unsigned YEAR_W   = 16;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned WDAY_W   = 3;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned ADD_W    = 17;

  localparam logic [ADD_W-1:0] MAX_ADD_SECONDS = 17'd86400;

  // x / 15 == (x * DIV15_MUL) >> DIV15_SHIFT for x below 2^15
  localparam logic [15:0] DIV15_MUL   = 16'd34953;
  localparam int unsigned DIV15_SHIFT = 19;

  // y divisible by 25 iff (y * INV25 mod 2^16) <= DIV25_LIMIT
  localparam logic [15:0] INV25       = 16'd23593;
  localparam logic [15:0] DIV25_LIMIT = 16'd2621;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] DAYS_SHORT = 5'd30;
  localparam logic [4:0] DAYS_LONG  = 5'd31;
  localparam logic [4:0] DAYS_FEB   = 5'd28;
  localparam logic [4:0] DAYS_LEAP  = 5'd29;

  function automatic logic [4:0] month_days(logic leap, logic [MONTH_W-1:0] month);
    logic [4:0] len;
    case (month)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
      MONTH_FEB: len = leap ? DAYS_LEAP : DAYS_FEB;
      default:   len = DAYS_LONG;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/cdas_in_if.sv =====
// ----------------------------------------------------------------------------
// cdas_in_if
// Input channel: starting date/time and seconds to add, valid/ready.
// ----------------------------------------------------------------------------
interface cdas_in_if
  import cdas_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   in_year;
  logic [MONTH_W-1:0]  in_month;
  logic [DAY_W-1:0]    in_day;
  logic [WDAY_W-1:0]   in_weekday;
  logic [HOUR_W-1:0]   in_hour;
  logic [MINUTE_W-1:0] in_minute;
  logic [SECOND_W-1:0] in_second;
  logic [ADD_W-1:0]    add_seconds;

  modport source (
    output valid, in_year, in_month, in_day, in_weekday, in_hour, in_minute,
           in_second, add_seconds,
    input  ready
  );

  modport sink (
    input  valid, in_year, in_month, in_day, in_weekday, in_hour, in_minute,
           in_second, add_seconds,
    output ready
  );
endinterface

// ===== rtl/cdas_out_if.sv =====
// ----------------------------------------------------------------------------
// cdas_out_if
// Output channel: resulting date/time, valid/ready.
// ----------------------------------------------------------------------------
interface cdas_out_if
  import cdas_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   out_year;
  logic [MONTH_W-1:0]  out_month;
  logic [DAY_W-1:0]    out_day;
  logic [WDAY_W-1:0]   out_weekday;
  logic [HOUR_W-1:0]   out_hour;
  logic [MINUTE_W-1:0] out_minute;
  logic [SECOND_W-1:0] out_second;

  modport source (
    output valid, out_year, out_month, out_day, out_weekday, out_hour,
           out_minute, out_second,
    input  ready
  );

  modport sink (
    input  valid, out_year, out_month, out_day, out_weekday, out_hour,
           out_minute, out_second,
    output ready
  );
endinterface

// ===== rtl/calendar_datetime_add_seconds.sv =====
// Advances a Gregorian date and time by up to one day (larger add amounts
// are clamped to 86400 s). The datapath is a seven-stage pipeline: a new
// transfer is taken every cycle unless a stalled output has backed up to the
// input, the last stage being the output register. Each stage has its
// own ready, so a stalled output only holds the stages behind it until a
// bubble is found; empty stages keep accepting input. No reset sequence or
// configuration is needed.
// ----------------------------------------------------------------------------
// calendar_datetime_add_seconds
// Seconds/minutes/hours carry chain, leap-year month rollover, year wrap.
// ----------------------------------------------------------------------------
`include "calendar_datetime_add_seconds_macros.svh"

module calendar_datetime_add_seconds
  import cdas_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  cdas_in_if.sink           in_i,
  cdas_out_if.source        out_o
);

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [WDAY_W-1:0]   wday;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [16:0]         sec_sum;
    logic [15:0]         y25;
  } st1_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [WDAY_W-1:0]   wday;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [16:0]         sec_sum;
    logic [10:0]         sec_q;
    logic                leap;
  } st2_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [WDAY_W-1:0]   wday;
    logic [HOUR_W-1:0]   hour;
    logic [SECOND_W-1:0] second;
    logic [10:0]         min_sum;
    logic                leap;
  } st3_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [WDAY_W-1:0]   wday;
    logic [HOUR_W-1:0]   hour;
    logic [SECOND_W-1:0] second;
    logic [10:0]         min_sum;
    logic [4:0]          min_q;
    logic                leap;
  } st4_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [WDAY_W-1:0]   wday;
    logic [SECOND_W-1:0] second;
    logic [MINUTE_W-1:0] minute;
    logic [5:0]          hour_sum;
    logic                leap;
  } st5_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [5:0]          day_sum;
    logic [3:0]          wday_sum;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic                leap;
  } st6_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [WDAY_W-1:0]   wday;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } res_t;

  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES:0]   rdy;

  st1_t st1_d, st1_q;
  st2_t st2_d, st2_q;
  st3_t st3_d, st3_q;
  st4_t st4_d, st4_q;
  st5_t st5_d, st5_q;
  st6_t st6_d, st6_q;
  res_t res_d, res_q;

  logic [ADD_W-1:0] add_clamped;
  logic [30:0]      sec_prod;
  logic [24:0]      min_prod;
  logic [1:0]       hour_carry;
  logic [4:0]       mlen;
  logic [4:0]       month_inc;

  // per-stage ready: a stage can load when empty or when it moves on
  always_comb begin
    rdy[NUM_STAGES] = out_o.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 1: clamp, second sum, year times inverse of 25
  always_comb begin
    add_clamped     = (in_i.add_seconds > MAX_ADD_SECONDS) ? MAX_ADD_SECONDS
                                                           : in_i.add_seconds;
    st1_d.year      = in_i.in_year;
    st1_d.month     = in_i.in_month;
    st1_d.day       = in_i.in_day;
    st1_d.wday      = in_i.in_weekday;
    st1_d.hour      = in_i.in_hour;
    st1_d.minute    = in_i.in_minute;
    st1_d.sec_sum   = 17'(in_i.in_second) + add_clamped;
    st1_d.y25       = in_i.in_year * INV25;
  end

  // stage 2: seconds / 60 as (x/4)/15, leap flag
  always_comb begin
    sec_prod      = 31'(st1_q.sec_sum[16:2]) * 31'(DIV15_MUL);
    st2_d.year    = st1_q.year;
    st2_d.month   = st1_q.month;
    st2_d.day     = st1_q.day;
    st2_d.wday    = st1_q.wday;
    st2_d.hour    = st1_q.hour;
    st2_d.minute  = st1_q.minute;
    st2_d.sec_sum = st1_q.sec_sum;
    st2_d.sec_q   = 11'(sec_prod >> DIV15_SHIFT);
    st2_d.leap    = (st1_q.year[1:0] == 2'd0) &&
                    ((st1_q.y25 > DIV25_LIMIT) || (st1_q.year[3:0] == 4'd0));
  end

  // stage 3: second remainder, minute sum
  always_comb begin
    st3_d.year    = st2_q.year;
    st3_d.month   = st2_q.month;
    st3_d.day     = st2_q.day;
    st3_d.wday    = st2_q.wday;
    st3_d.hour    = st2_q.hour;
    st3_d.second  = 6'(st2_q.sec_sum - 17'(st2_q.sec_q) * 17'd60);
    st3_d.min_sum = 11'(st2_q.minute) + st2_q.sec_q;
    st3_d.leap    = st2_q.leap;
  end

  // stage 4: minutes / 60
  always_comb begin
    min_prod      = 25'(st3_q.min_sum[10:2]) * 25'(DIV15_MUL);
    st4_d.year    = st3_q.year;
    st4_d.month   = st3_q.month;
    st4_d.day     = st3_q.day;
    st4_d.wday    = st3_q.wday;
    st4_d.hour    = st3_q.hour;
    st4_d.second  = st3_q.second;
    st4_d.min_sum = st3_q.min_sum;
    st4_d.min_q   = 5'(min_prod >> DIV15_SHIFT);
    st4_d.leap    = st3_q.leap;
  end

  // stage 5: minute remainder, hour sum
  always_comb begin
    st5_d.year     = st4_q.year;
    st5_d.month    = st4_q.month;
    st5_d.day      = st4_q.day;
    st5_d.wday     = st4_q.wday;
    st5_d.second   = st4_q.second;
    st5_d.minute   = 6'(st4_q.min_sum - 11'(st4_q.min_q) * 11'd60);
    st5_d.hour_sum = 6'(st4_q.hour) + 6'(st4_q.min_q);
    st5_d.leap     = st4_q.leap;
  end

  // stage 6: hours / 24 (at most two days), day and weekday sums
  always_comb begin
    if (st5_q.hour_sum >= 6'd48) begin
      hour_carry = 2'd2;
    end else if (st5_q.hour_sum >= 6'd24) begin
      hour_carry = 2'd1;
    end else begin
      hour_carry = 2'd0;
    end
    st6_d.year     = st5_q.year;
    st6_d.month    = st5_q.month;
    st6_d.day_sum  = 6'(st5_q.day) + 6'(hour_carry);
    st6_d.wday_sum = 4'(st5_q.wday) + 4'(hour_carry);
    st6_d.hour     = 5'(st5_q.hour_sum - 6'(hour_carry) * 6'd24);
    st6_d.minute   = st5_q.minute;
    st6_d.second   = st5_q.second;
    st6_d.leap     = st5_q.leap;
  end

  // stage 7: weekday mod 7, month and year rollover
  always_comb begin
    mlen       = month_days(st6_q.leap, st6_q.month);
    month_inc  = 5'(st6_q.month) + 5'd1;
    res_d.wday = (st6_q.wday_sum >= 4'd7) ? 3'(st6_q.wday_sum - 4'd7)
                                          : 3'(st6_q.wday_sum);
    res_d.hour   = st6_q.hour;
    res_d.minute = st6_q.minute;
    res_d.second = st6_q.second;
    res_d.year   = st6_q.year;
    res_d.month  = st6_q.month;
    res_d.day    = 5'(st6_q.day_sum);
    if (st6_q.day_sum > 6'(mlen)) begin
      res_d.day = 5'(st6_q.day_sum - 6'(mlen));
      if (month_inc > 5'(MONTH_DEC)) begin
        res_d.month = 4'(month_inc - 5'(MONTH_DEC));
        res_d.year  = st6_q.year + 16'd1;
      end else begin
        res_d.month = 4'(month_inc);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      st1_q <= st1_d;
    end
    if (rdy[1]) begin
      st2_q <= st2_d;
    end
    if (rdy[2]) begin
      st3_q <= st3_d;
    end
    if (rdy[3]) begin
      st4_q <= st4_d;
    end
    if (rdy[4]) begin
      st5_q <= st5_d;
    end
    if (rdy[5]) begin
      st6_q <= st6_d;
    end
    if (rdy[6]) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = vld_q[NUM_STAGES-1];
  assign out_o.out_year    = res_q.year;
  assign out_o.out_month   = res_q.month;
  assign out_o.out_day     = res_q.day;
  assign out_o.out_weekday = res_q.wday;
  assign out_o.out_hour    = res_q.hour;
  assign out_o.out_minute  = res_q.minute;
  assign out_o.out_second  = res_q.second;

  `CDAS_ASSERT_IMPL(a_empty_out_takes_input, clk_i, rst_ni, !out_o.valid, in_i.ready)
  `CDAS_ASSERT_IMPL(a_second_in_range, clk_i, rst_ni, out_o.valid, out_o.out_second < 6'd60)
  `CDAS_ASSERT_IMPL(a_minute_in_range, clk_i, rst_ni, out_o.valid, out_o.out_minute < 6'd60)
  `CDAS_ASSERT_IMPL(a_hour_in_range, clk_i, rst_ni, out_o.valid, out_o.out_hour < 5'd24)
  `CDAS_ASSERT_IMPL(a_weekday_in_range, clk_i, rst_ni, out_o.valid, out_o.out_weekday < 3'd7)
  `CDAS_ASSERT_NEXT(a_stalled_stage_holds, clk_i, rst_ni, !rdy[NUM_STAGES-2], $stable(st6_q))

endmodule
